// ===== design/key_autorepeat_tracker_unit_macros.svh =====
// assertion macros for the key autorepeat tracker
// used by the top level only, no other dependencies
`ifndef KEY_AUTOREPEAT_TRACKER_UNIT_MACROS_SVH
`define KEY_AUTOREPEAT_TRACKER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define KATU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("katu: same-cycle check failed");
// next-cycle implication
`define KATU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("katu: next-cycle check failed");
`else
`define KATU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KATU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/katu_pkg.sv =====
// shared types and constants of the key autorepeat tracker
// no dependencies
package katu_pkg;

    localparam int KATU_NUM_KEYS   = 512;
    localparam int KATU_TIME_WIDTH = 32;

    localparam int REQ_TYPE_W = 3;
    localparam int KEY_IDX_W  = 9;
    localparam int IN_TIME_W  = 32;
    localparam int HELD_W     = 32;
    // wide enough for any key index and any key count
    localparam int KEY_CMP_W  = 11;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_DOWN = 3'd0,
        REQ_UP   = 3'd1,
        REQ_TICK = 3'd2,
        REQ_READ = 3'd3,
        REQ_SET  = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_WALK,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic capture;
        logic ptr_load;
        logic ptr_zero;
        logic issue;
        logic clr_we;
    } dp_cmd_t;

    typedef struct packed {
        logic key_ok;
        logic ptr_last;
        logic pipe_empty;
    } dp_sts_t;

endpackage

// ===== design/katu_req_if.sv =====
// request channel of the key autorepeat tracker
// depends on katu_pkg
interface katu_req_if import katu_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [KEY_IDX_W-1:0]  key_index;
    logic                  is_os_repeat;
    logic [IN_TIME_W-1:0]  elapsed_time;
    logic [IN_TIME_W-1:0]  repeat_delay;
    logic [IN_TIME_W-1:0]  repeat_period;

    modport source (
        output valid, req_type, key_index, is_os_repeat,
               elapsed_time, repeat_delay, repeat_period,
        input  ready
    );

    modport sink (
        input  valid, req_type, key_index, is_os_repeat,
               elapsed_time, repeat_delay, repeat_period,
        output ready
    );

endinterface

// ===== design/katu_rsp_if.sv =====
// response channel of the key autorepeat tracker
// depends on katu_pkg
interface katu_rsp_if import katu_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              is_active;
    logic              is_clicked;
    logic              is_repeating;
    logic [HELD_W-1:0] held_time;

    modport source (
        output valid, is_active, is_clicked, is_repeating, held_time,
        input  ready
    );

    modport sink (
        input  valid, is_active, is_clicked, is_repeating, held_time,
        output ready
    );

endinterface

// ===== design/katu_ctrl.sv =====
// sequencer of the key autorepeat tracker: clearing pass, single access, table walk
// depends on katu_pkg
module katu_ctrl import katu_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [REQ_TYPE_W-1:0] req_type,
    input  logic                  is_os_repeat,
    input  dp_sts_t               sts,
    output dp_cmd_t               cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_we = 1'b1;
                if (sts.ptr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    unique case (req_t'(req_type))
                        REQ_DOWN:
                        begin
                            if (sts.key_ok && !is_os_repeat)
                            begin
                                cmd.ptr_load = 1'b1;
                                state_next   = ST_ISSUE;
                            end
                        end
                        REQ_UP, REQ_SET:
                        begin
                            if (sts.key_ok)
                            begin
                                cmd.ptr_load = 1'b1;
                                state_next   = ST_ISSUE;
                            end
                        end
                        REQ_READ:
                        begin
                            // out-of-range read still answers, with zeros
                            cmd.ptr_load = 1'b1;
                            state_next   = ST_ISSUE;
                        end
                        REQ_TICK:
                        begin
                            cmd.ptr_zero = 1'b1;
                            state_next   = ST_WALK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ISSUE:
            begin
                cmd.issue  = 1'b1;
                state_next = ST_DRAIN;
            end
            ST_WALK:
            begin
                cmd.issue = 1'b1;
                if (sts.ptr_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (sts.pipe_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/katu_dpath.sv =====
// key table memory, update pipeline and response register of the tracker
// depends on katu_pkg
module katu_dpath import katu_pkg::*; #(
    parameter int NUM_KEYS   = KATU_NUM_KEYS,
    parameter int TIME_WIDTH = KATU_TIME_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_sts_t               sts,
    input  logic [REQ_TYPE_W-1:0] req_type,
    input  logic [KEY_IDX_W-1:0]  key_index,
    input  logic [IN_TIME_W-1:0]  elapsed_time,
    input  logic [IN_TIME_W-1:0]  repeat_delay,
    input  logic [IN_TIME_W-1:0]  repeat_period,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic                  is_active,
    output logic                  is_clicked,
    output logic                  is_repeating,
    output logic [HELD_W-1:0]     held_time
);

    localparam int TW      = TIME_WIDTH;
    localparam int KEY_AW  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int ENTRY_W = 3 + 3 * TW;

    // entry layout: active, clicked, repeating, held time, delay, period
    logic [ENTRY_W-1:0] mem [NUM_KEYS];

    logic [KEY_AW-1:0] ptr_reg;
    logic [KEY_AW-1:0] ptr_next;
    logic              key_ok;
    logic              ptr_last;

    req_t          op_reg;
    logic          ok_reg;
    logic [TW-1:0] dt_reg;
    logic [TW-1:0] dly_reg;
    logic [TW-1:0] per_reg;

    logic               s1_vld_reg;
    logic [KEY_AW-1:0]  s1_addr_reg;
    logic [ENTRY_W-1:0] rd_data_reg;

    logic              s2_vld_reg;
    logic [KEY_AW-1:0] s2_addr_reg;
    logic              s2_act_reg;
    logic              s2_clk_reg;
    logic              s2_rep_reg;
    logic [TW-1:0]     s2_time_reg;
    logic [TW-1:0]     s2_dly_reg;
    logic [TW-1:0]     s2_per_reg;

    logic          rd_act;
    logic          rd_clk;
    logic          rd_rep;
    logic [TW-1:0] rd_time;
    logic [TW-1:0] rd_dly;
    logic [TW-1:0] rd_per;
    logic [TW:0]   sum;
    logic [TW-1:0] time_sat;

    logic          gt_dly;
    logic [TW:0]   diff;
    logic          gt_per;
    logic [TW-1:0] time_sub;

    logic               out_free;
    logic               stall;
    logic               rsp_load;
    logic               wr_en;
    logic [ENTRY_W-1:0] wr_data;
    logic               n_act;
    logic               n_clk;
    logic               n_rep;
    logic [TW-1:0]      n_time;
    logic [TW-1:0]      n_dly;
    logic [TW-1:0]      n_per;

    logic              rsp_vld_reg;
    logic              rsp_act_reg;
    logic              rsp_clk_reg;
    logic              rsp_rep_reg;
    logic [HELD_W-1:0] rsp_time_reg;

    // address pointer
    assign key_ok   = KEY_CMP_W'(key_index) < KEY_CMP_W'(NUM_KEYS);
    assign ptr_last = ptr_reg == KEY_AW'(NUM_KEYS - 1);

    always_comb
    begin
        ptr_next = ptr_reg;
        priority if (cmd.ptr_zero)
        begin
            ptr_next = '0;
        end
        else if (cmd.ptr_load)
        begin
            ptr_next = key_ok ? KEY_AW'(key_index) : '0;
        end
        else if (cmd.issue || cmd.clr_we)
        begin
            ptr_next = ptr_last ? '0 : ptr_reg + KEY_AW'(1);
        end
        else
        begin
            ptr_next = ptr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= req_t'(req_type);
            ok_reg  <= key_ok;
            dt_reg  <= TW'(elapsed_time);
            dly_reg <= TW'(repeat_delay);
            per_reg <= TW'(repeat_period);
        end
    end

    // a read waits in the last stage while the response register is full
    assign out_free = !rsp_vld_reg || rsp_ready;
    assign stall    = s2_vld_reg && (op_reg == REQ_READ) && !out_free;
    assign rsp_load = s2_vld_reg && (op_reg == REQ_READ) && out_free;

    // memory read port
    always_ff @(posedge clk)
    begin
        if (cmd.issue && !stall)
        begin
            rd_data_reg <= mem[ptr_reg];
            s1_addr_reg <= ptr_reg;
        end
    end

    // memory write port
    always_ff @(posedge clk)
    begin
        if (cmd.clr_we)
        begin
            mem[ptr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[s2_addr_reg] <= wr_data;
        end
    end

    // stage 2: saturating add of the elapsed time
    assign rd_act  = rd_data_reg[ENTRY_W-1];
    assign rd_clk  = rd_data_reg[ENTRY_W-2];
    assign rd_rep  = rd_data_reg[ENTRY_W-3];
    assign rd_time = rd_data_reg[3*TW-1:2*TW];
    assign rd_dly  = rd_data_reg[2*TW-1:TW];
    assign rd_per  = rd_data_reg[TW-1:0];

    assign sum      = {1'b0, rd_time} + {1'b0, dt_reg};
    assign time_sat = sum[TW] ? '1 : sum[TW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (!stall)
        begin
            s1_vld_reg <= cmd.issue;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            s2_addr_reg <= s1_addr_reg;
            s2_act_reg  <= rd_act;
            s2_clk_reg  <= rd_clk;
            s2_rep_reg  <= rd_rep;
            s2_time_reg <= (op_reg == REQ_TICK && rd_act) ? time_sat : rd_time;
            s2_dly_reg  <= rd_dly;
            s2_per_reg  <= rd_per;
        end
    end

    // stage 3: repeat decision and write back
    assign gt_dly   = s2_time_reg > s2_dly_reg;
    assign diff     = {1'b0, s2_time_reg} - {1'b0, s2_per_reg};
    assign gt_per   = !diff[TW] && (diff[TW-1:0] != '0);
    assign time_sub = gt_per ? diff[TW-1:0] : '0;

    always_comb
    begin
        n_act  = s2_act_reg;
        n_clk  = s2_clk_reg;
        n_rep  = s2_rep_reg;
        n_time = s2_time_reg;
        n_dly  = s2_dly_reg;
        n_per  = s2_per_reg;
        unique case (op_reg)
            REQ_DOWN:
            begin
                n_act = 1'b1;
                n_clk = 1'b1;
            end
            REQ_UP:
            begin
                n_act  = 1'b0;
                n_clk  = 1'b0;
                n_rep  = 1'b0;
                n_time = '0;
            end
            REQ_SET:
            begin
                n_dly = dly_reg;
                n_per = per_reg;
            end
            REQ_TICK:
            begin
                if (s2_act_reg)
                begin
                    if (gt_dly && (s2_dly_reg != '0) && (s2_per_reg != '0))
                    begin
                        n_rep  = 1'b1;
                        n_clk  = 1'b1;
                        n_time = time_sub;
                    end
                    else
                    begin
                        n_clk = 1'b0;
                    end
                end
            end
            default:
            begin
                n_act = s2_act_reg;
            end
        endcase
    end

    assign wr_en   = s2_vld_reg && (op_reg != REQ_READ);
    assign wr_data = {n_act, n_clk, n_rep, n_time, n_dly, n_per};

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_vld_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_act_reg  <= ok_reg && s2_act_reg;
            rsp_clk_reg  <= ok_reg && s2_clk_reg;
            rsp_rep_reg  <= ok_reg && s2_rep_reg;
            rsp_time_reg <= ok_reg ? HELD_W'(s2_time_reg) : '0;
        end
    end

    assign rsp_valid    = rsp_vld_reg;
    assign is_active    = rsp_act_reg;
    assign is_clicked   = rsp_clk_reg;
    assign is_repeating = rsp_rep_reg;
    assign held_time    = rsp_time_reg;

    assign sts.key_ok     = key_ok;
    assign sts.ptr_last   = ptr_last;
    assign sts.pipe_empty = !s1_vld_reg && !s2_vld_reg;

endmodule

// ===== design/key_autorepeat_tracker_unit.sv =====
// key autorepeat tracker: per-key held, clicked and repeat state with tick walk
// after reset a clearing pass zeroes every entry of the key table; no request is taken then
// key down, key up, set repeat and read pass one key through the update pipeline and then wait
// for it to drain, a read result waiting while the response register is full; a tick walks all
// keys, one per cycle via the single read and single write port; other requests skip the table
// depends on katu_pkg, katu_req_if, katu_rsp_if, katu_ctrl, katu_dpath and the macro header
`include "key_autorepeat_tracker_unit_macros.svh"

module key_autorepeat_tracker_unit import katu_pkg::*; #(
    parameter int NUM_KEYS   = KATU_NUM_KEYS,
    parameter int TIME_WIDTH = KATU_TIME_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    katu_req_if.sink    req,
    katu_rsp_if.source  rsp
);

    // command and status between sequencer and datapath
    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer: clearing pass, request decode, single access or full table walk
    katu_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (req.valid),
        .in_ready     (req.ready),
        .req_type     (req.req_type),
        .is_os_repeat (req.is_os_repeat),
        .sts          (sts),
        .cmd          (cmd)
    );

    // datapath: key table, three-stage update pipeline, response register
    // the response register lets a new request in while a read result waits
    katu_dpath #(
        .NUM_KEYS   (NUM_KEYS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .req_type      (req.req_type),
        .key_index     (req.key_index),
        .elapsed_time  (req.elapsed_time),
        .repeat_delay  (req.repeat_delay),
        .repeat_period (req.repeat_period),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .is_active     (rsp.is_active),
        .is_clicked    (rsp.is_clicked),
        .is_repeating  (rsp.is_repeating),
        .held_time     (rsp.held_time)
    );

    // a request transfer only happens once the update pipeline has drained
    `KATU_ASSERT_IMPL(a_accept_drained, clk, rst_n, req.valid && req.ready, sts.pipe_empty)

    // the clearing pass runs alone: no pipeline traffic, no request taken
    `KATU_ASSERT_IMPL(a_clear_alone, clk, rst_n, cmd.clr_we, sts.pipe_empty && !req.ready)

    // a request that needs no table access never starts a memory read
    `KATU_ASSERT_NEXT(a_no_stray_issue, clk, rst_n, cmd.capture && !cmd.ptr_load && !cmd.ptr_zero, !cmd.issue)

endmodule
